// ===== rtl/core/aes_pkg.sv =====
// Shared constants, types and decode helpers for the ANSI escape stripper.
package aes_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned STATE_W = 3;

	// Parser state codes
	localparam logic [STATE_W-1:0] ST_NORMAL     = 3'd0;
	localparam logic [STATE_W-1:0] ST_ESC        = 3'd1;
	localparam logic [STATE_W-1:0] ST_ESC_INTERM = 3'd2;
	localparam logic [STATE_W-1:0] ST_CSI        = 3'd3;
	localparam logic [STATE_W-1:0] ST_OSC        = 3'd4;
	localparam logic [STATE_W-1:0] ST_OSC_ESC    = 3'd5;

	// Byte codes
	localparam logic [BYTE_W-1:0] BYTE_BEL       = 8'h07;
	localparam logic [BYTE_W-1:0] BYTE_TAB       = 8'h09;
	localparam logic [BYTE_W-1:0] BYTE_LF        = 8'h0A;
	localparam logic [BYTE_W-1:0] BYTE_CR        = 8'h0D;
	localparam logic [BYTE_W-1:0] BYTE_ESC       = 8'h1B;
	localparam logic [BYTE_W-1:0] BYTE_SPACE     = 8'h20;
	localparam logic [BYTE_W-1:0] BYTE_HASH      = 8'h23;
	localparam logic [BYTE_W-1:0] BYTE_PERCENT   = 8'h25;
	localparam logic [BYTE_W-1:0] BYTE_LPAREN    = 8'h28;
	localparam logic [BYTE_W-1:0] BYTE_RPAREN    = 8'h29;
	localparam logic [BYTE_W-1:0] BYTE_STAR      = 8'h2A;
	localparam logic [BYTE_W-1:0] BYTE_PLUS      = 8'h2B;
	localparam logic [BYTE_W-1:0] BYTE_FINAL_LO  = 8'h40;
	localparam logic [BYTE_W-1:0] BYTE_LBRACKET  = 8'h5B;
	localparam logic [BYTE_W-1:0] BYTE_BACKSLASH = 8'h5C;
	localparam logic [BYTE_W-1:0] BYTE_RBRACKET  = 8'h5D;
	localparam logic [BYTE_W-1:0] BYTE_FINAL_HI  = 8'h7E;
	localparam logic [BYTE_W-1:0] BYTE_DEL       = 8'h7F;

	// Decision for one byte: pass it on or not, and where the parser goes
	typedef struct packed {
		logic               keep;
		logic [STATE_W-1:0] next_state;
	} aes_dec_t;

	function automatic logic is_intermediate(input logic [BYTE_W-1:0] b);
		is_intermediate = (b == BYTE_SPACE) || (b == BYTE_HASH) || (b == BYTE_LPAREN) ||
			(b == BYTE_RPAREN) || (b == BYTE_STAR) || (b == BYTE_PLUS) ||
			(b == BYTE_PERCENT);
	endfunction

	function automatic logic is_text(input logic [BYTE_W-1:0] b);
		is_text = (b == BYTE_CR) || (b == BYTE_LF) || (b == BYTE_TAB) ||
			((b >= BYTE_SPACE) && (b != BYTE_DEL));
	endfunction

endpackage

// ===== rtl/core/aes_parser.sv =====
// Escape sequence parser: next state and keep decision for one byte.
module aes_parser (
	input  logic [aes_pkg::STATE_W-1:0] state,
	input  logic [aes_pkg::BYTE_W-1:0]  data,
	output aes_pkg::aes_dec_t           dec
);
	import aes_pkg::*;

	always_comb begin
		dec.keep       = 1'b0;
		dec.next_state = ST_NORMAL;
		case (state)
			ST_ESC: begin
				if (data == BYTE_LBRACKET) begin
					dec.next_state = ST_CSI;
				end else if (data == BYTE_RBRACKET) begin
					dec.next_state = ST_OSC;
				end else if (is_intermediate(data)) begin
					dec.next_state = ST_ESC_INTERM;
				end
			end
			ST_ESC_INTERM: begin
				dec.next_state = ST_NORMAL;
			end
			ST_CSI: begin
				if (!((data >= BYTE_FINAL_LO) && (data <= BYTE_FINAL_HI))) begin
					dec.next_state = ST_CSI;
				end
			end
			ST_OSC: begin
				if (data == BYTE_ESC) begin
					dec.next_state = ST_OSC_ESC;
				end else if (data != BYTE_BEL) begin
					dec.next_state = ST_OSC;
				end
			end
			ST_OSC_ESC: begin
				// a non-terminator is dropped, and the byte after it is read as the byte after an ESC
				dec.next_state = (data == BYTE_BACKSLASH) ? ST_NORMAL : ST_ESC;
			end
			default: begin
				if (data == BYTE_ESC) begin
					dec.next_state = ST_ESC;
				end else begin
					dec.keep = is_text(data);
				end
			end
		endcase
	end

endmodule

// ===== rtl/core/aes_out_reg.sv =====
// Output word register with stream handshake toward the consumer.
module aes_out_reg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic [aes_pkg::BYTE_W-1:0] load_data,
	output logic                       free,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [aes_pkg::BYTE_W-1:0] m_tdata
);
	import aes_pkg::*;

	logic                valid_q;
	logic [BYTE_W-1:0]   data_q;

	assign free     = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

endmodule

// ===== rtl/core/ansi_escape_stripper_core.sv =====
// A kept word goes through the input register, then the output register, to m_tdata.
// Throughput: one word per cycle while m_tready stays high; the parser state loop is one
// register plus a small byte decode, so nothing limits the rate below that.
// Words inside escape sequences and non-layout controls are dropped and produce no output.
// Reset (arst_n low, asynchronous): both stages empty, parser in normal text state.
module ansi_escape_stripper_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [aes_pkg::BYTE_W-1:0] s_tdata,  // [7:0] in_byte
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [aes_pkg::BYTE_W-1:0] m_tdata   // [7:0] kept_byte
);
	import aes_pkg::*;

	// Input stage: holds one word until the output register can take it
	logic               valid_s1;
	logic [BYTE_W-1:0]  data_s1;

	// Parser state, advanced only when the stage-1 word is consumed
	logic [STATE_W-1:0] state_q;

	aes_dec_t dec;
	logic     out_free;
	logic     advance;

	// Advance whenever the output slot is free; dropped words advance too
	assign advance  = valid_s1 && out_free;
	// Take a new word when stage 1 is empty or draining this cycle
	assign s_tready = !valid_s1 || advance;

	aes_parser u_parser (
		.state (state_q),
		.data  (data_s1),
		.dec   (dec)
	);

	aes_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && dec.keep),
		.load_data (data_s1),
		.free      (out_free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= ST_NORMAL;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				state_q <= dec.next_state;
			end
		end
	end

	// Hold the payload while stage 1 is stalled
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
		end
	end

	// Parser must not move unless a word is consumed
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("parser state changed without a consumed word");

	// Nothing inside an escape sequence is ever passed on
	a_escape_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && state_q != ST_NORMAL) |-> !dec.keep)
		else $error("word kept while inside an escape sequence");

	// ESC and DEL never reach the output
	a_no_ctrl_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata != BYTE_ESC && m_tdata != BYTE_DEL))
		else $error("control byte on output");

	// A full, blocked input stage must refuse new words
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |-> !s_tready)
		else $error("input accepted while stage 1 is blocked");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for ansi_escape_stripper_core: directed and random bytes, scoreboard.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import aes_pkg::*;

	localparam int N_RANDOM     = 1600;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [BYTE_W-1:0]  s_tdata  = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [BYTE_W-1:0]  m_tdata;

	// Raw terminal bytes still to send, and the text bytes expected back
	logic [BYTE_W-1:0]  term_bytes_q[$];
	logic [BYTE_W-1:0]  kept_bytes_q[$];
	logic [STATE_W-1:0] parser_st = ST_NORMAL;
	int                 err_cnt   = 0;
	int                 cycle_cnt = 0;

	// Idle and stall bookkeeping of the source and sink sides
	int                 src_gap_left   = 0;
	bit                 src_quiet      = 1'b0;
	int                 snk_stall_left = 0;
	bit                 snk_quiet      = 1'b0;

	ansi_escape_stripper_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [7:0] in_byte
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)    // [7:0] kept_byte
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Append one byte to the send queue
	function automatic void put_term(input logic [BYTE_W-1:0] b);
		term_bytes_q = {term_bytes_q, b};
	endfunction

	// Append one byte to the expected queue
	function automatic void put_kept(input logic [BYTE_W-1:0] b);
		kept_bytes_q = {kept_bytes_q, b};
	endfunction

	// Advance the escape parser by one byte; return 1 when the byte passes as text.
	function automatic logic strip_step(input logic [BYTE_W-1:0] b);
		logic keep;
		keep = 1'b0;
		case (parser_st)
			ST_ESC: begin
				if (b == BYTE_LBRACKET)
					parser_st = ST_CSI;
				else if (b == BYTE_RBRACKET)
					parser_st = ST_OSC;
				else if (b inside {BYTE_SPACE, BYTE_HASH, BYTE_PERCENT, BYTE_LPAREN,
						BYTE_RPAREN, BYTE_STAR, BYTE_PLUS})
					parser_st = ST_ESC_INTERM;
				else
					parser_st = ST_NORMAL;
			end
			ST_ESC_INTERM: parser_st = ST_NORMAL;
			ST_CSI: begin
				if (b >= BYTE_FINAL_LO && b <= BYTE_FINAL_HI)
					parser_st = ST_NORMAL;
			end
			ST_OSC: begin
				if (b == BYTE_BEL)
					parser_st = ST_NORMAL;
				else if (b == BYTE_ESC)
					parser_st = ST_OSC_ESC;
			end
			// a non-backslash after ESC in OSC restarts the escape
			ST_OSC_ESC: parser_st = (b == BYTE_BACKSLASH) ? ST_NORMAL : ST_ESC;
			default: begin
				parser_st = (b == BYTE_ESC) ? ST_ESC : ST_NORMAL;
				keep = (b inside {BYTE_CR, BYTE_LF, BYTE_TAB}) ||
					(b >= BYTE_SPACE && b != BYTE_DEL);
			end
		endcase
		return keep;
	endfunction

	// Source side: hold a word until taken, then wait a drawn gap before the next one.
	always @(posedge clk) begin : feed_proc
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (s_tvalid) begin
				if (strip_step(s_tdata))
					put_kept(s_tdata);
				if ($urandom_range(0, 39) == 0)
					src_quiet = !src_quiet;
				src_gap_left = src_quiet ? 0 : int'($urandom_range(0, 9));
			end
			if (src_gap_left > 0 || term_bytes_q.size() == 0) begin
				if (src_gap_left > 0)
					src_gap_left--;
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata  <= term_bytes_q.pop_front();
			end
		end
	end

	// Sink side: compare each word with the oldest expected byte, then stall a drawn time.
	always @(posedge clk) begin : check_proc
		logic [BYTE_W-1:0] want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (kept_bytes_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("unexpected word: got %02h, nothing expected", m_tdata);
				end else begin
					want = kept_bytes_q.pop_front();
					if (m_tdata !== want) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("kept_byte mismatch: expected %02h, got %02h", want, m_tdata);
					end
				end
				if ($urandom_range(0, 39) == 0)
					snk_quiet = !snk_quiet;
				snk_stall_left = snk_quiet ? 0 : int'($urandom_range(0, 9));
			end
			if (snk_stall_left > 0) begin
				snk_stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : run_proc
		logic [BYTE_W-1:0] interm[7];
		int                n_directed;
		int                len;
		interm = '{BYTE_SPACE, BYTE_HASH, BYTE_PERCENT, BYTE_LPAREN, BYTE_RPAREN,
			BYTE_STAR, BYTE_PLUS};

		// Directed: field extremes, layout controls, C1, CSI with lowest and highest
		// final, OSC ended by BEL and by string terminator, ESC restart inside OSC,
		// and a plain two-byte escape.
		term_bytes_q = {8'h00, 8'hFF, BYTE_DEL, BYTE_CR, BYTE_LF, BYTE_TAB, 8'h80,
			BYTE_ESC, BYTE_LBRACKET, BYTE_FINAL_LO,
			BYTE_ESC, BYTE_LBRACKET, 8'h31, BYTE_FINAL_HI,
			BYTE_ESC, BYTE_RBRACKET, BYTE_BEL,
			BYTE_ESC, BYTE_RBRACKET, BYTE_ESC, BYTE_BACKSLASH,
			BYTE_ESC, BYTE_RBRACKET, BYTE_ESC, BYTE_LPAREN, 8'h42,
			BYTE_ESC, 8'h37, 8'h41};
		n_directed = term_bytes_q.size();

		// Random: mostly well-formed sequences with random content, some noise
		while (term_bytes_q.size() < n_directed + N_RANDOM) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					len = $urandom_range(1, 12);
					repeat (len) begin
						if ($urandom_range(0, 7) == 0)
							put_term($urandom_range(0, 1) ? BYTE_CR :
								($urandom_range(0, 1) ? BYTE_LF : BYTE_TAB));
						else
							put_term(BYTE_W'($urandom_range(8'h20, 8'hFF)));
					end
				end
				3, 4: begin
					put_term(BYTE_ESC);
					put_term(BYTE_LBRACKET);
					len = $urandom_range(0, 4);
					repeat (len) put_term(BYTE_W'($urandom_range(8'h30, 8'h3F)));
					if ($urandom_range(0, 3) == 0)
						put_term(BYTE_W'($urandom_range(8'h20, 8'h2F)));
					put_term(BYTE_W'($urandom_range(BYTE_FINAL_LO, BYTE_FINAL_HI)));
				end
				5: begin
					put_term(BYTE_ESC);
					put_term(BYTE_RBRACKET);
					len = $urandom_range(0, 10);
					repeat (len) put_term(BYTE_W'($urandom_range(8'h20, 8'hFF)));
					if ($urandom_range(0, 1)) begin
						put_term(BYTE_BEL);
					end else begin
						put_term(BYTE_ESC);
						put_term(BYTE_BACKSLASH);
					end
				end
				6: begin
					put_term(BYTE_ESC);
					put_term(interm[$urandom_range(0, 6)]);
					put_term(BYTE_W'($urandom_range(0, 255)));
				end
				7: begin
					put_term(BYTE_ESC);
					put_term(BYTE_W'($urandom_range(0, 255)));
				end
				8: begin
					len = $urandom_range(1, 6);
					repeat (len) put_term(BYTE_W'($urandom_range(0, 255)));
				end
				default: begin
					// broken sequence: opener followed by arbitrary bytes
					put_term(BYTE_ESC);
					put_term($urandom_range(0, 1) ? BYTE_LBRACKET : BYTE_RBRACKET);
					len = $urandom_range(0, 5);
					repeat (len) put_term(BYTE_W'($urandom_range(0, 255)));
				end
			endcase
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (term_bytes_q.size() != 0 || s_tvalid)
			@(negedge clk);
		while (kept_bytes_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (err_cnt == 0 && kept_bytes_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/aes_pkg.sv
rtl/core/aes_parser.sv
rtl/core/aes_out_reg.sv
rtl/core/ansi_escape_stripper_core.sv
dv/testbench.sv
